[design/rswct_pkg.sv]
package rswct_pkg;

  localparam int VALUE_W = 32;
  localparam int TAG_W   = 4;
  localparam int LEN_W   = 5;

  localparam logic [LEN_W-1:0] LEN_RESET = 5'd3;

  typedef logic signed [VALUE_W-1:0] value_t;

  // One tagged value on its way from the front to the back.
  typedef struct packed {
    value_t             value;
    logic [TAG_W-1:0]   tag;
    logic               last;
  } q_entry_t;

  typedef enum logic [1:0] {
    BK_LOAD,
    BK_SORT,
    BK_EMIT
  } bk_state_t;

endpackage

[design/rswct_if.sv]
interface rswct_in_if
  import rswct_pkg::*;
  ();
  logic   valid;
  logic   ready;
  value_t sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink   (input valid, input sample_value, output ready);
endinterface

interface rswct_out_if
  import rswct_pkg::*;
  ();
  logic             valid;
  logic             ready;
  value_t           sorted_value;
  logic [TAG_W-1:0] column_index;
  logic             row_done;

  modport source (output valid, output sorted_value, output column_index, output row_done,
                  input ready);
  modport sink   (input valid, input sorted_value, input column_index, input row_done,
                  output ready);
endinterface

[design/row_sort_with_column_tags.sv]
// Throughput: the back loads a row of n values at one per cycle while the queue
// holds values, sorts it in n compare-swap phases and emits it at one result per
// cycle while the output is not stalled. The front takes one value per cycle while
// the queue is not full, so the next row can enter the queue while the back sorts.
// Reset (rst_n, synchronous, active low) clears counters, queue and output valid,
// and sets row_length to 3; the row cells are not cleared.
module row_sort_with_column_tags
  import rswct_pkg::*;
#(
  parameter int ROW_MAX = 16,
  parameter int Q_DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata,
  rswct_in_if.sink         in_ch,
  rswct_out_if.source      out_ch
);

  logic [LEN_W-1:0] row_len_r;
  logic             q_push, q_full, q_pop, q_not_empty;
  q_entry_t         q_push_data, q_pop_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_len_r <= LEN_RESET;
    end else if (cfg_we) begin
      row_len_r <= cfg_wdata;
    end
  end

  rswct_front #(.ROW_MAX(ROW_MAX)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .row_len   (row_len_r),
    .in_ch     (in_ch),
    .push      (q_push),
    .push_data (q_push_data),
    .q_full    (q_full)
  );

  rswct_fifo #(.DEPTH(Q_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_pop_data)
  );

  rswct_back #(.ROW_MAX(ROW_MAX)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_we),
    .q_valid (q_not_empty),
    .q_data  (q_pop_data),
    .pop     (q_pop),
    .out_ch  (out_ch)
  );

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue written while full");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_not_empty)
    else $error("queue read while empty");

  // A result held by back-pressure stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.sorted_value)
      && $stable(out_ch.column_index) && $stable(out_ch.row_done)))
    else $error("result changed while stalled");

endmodule

[design/rswct_front.sv]
module rswct_front
  import rswct_pkg::*;
#(
  parameter int ROW_MAX = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] row_len,
  rswct_in_if.sink         in_ch,
  output logic             push,
  output q_entry_t         push_data,
  input  logic             q_full
);

  localparam int CNT_W = $clog2(ROW_MAX + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] eff_len;
  logic             last;

  // A length of zero means one; lengths above the row storage saturate.
  always_comb begin
    if (row_len == '0) begin
      eff_len = CNT_W'(1);
    end else if (32'(row_len) > ROW_MAX) begin
      eff_len = CNT_W'(ROW_MAX);
    end else begin
      eff_len = CNT_W'(row_len);
    end
  end

  assign last        = (cnt_r + CNT_W'(1)) == eff_len;
  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  assign push_data.value = in_ch.sample_value;
  assign push_data.tag   = TAG_W'(cnt_r);
  assign push_data.last  = last;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push) begin
      cnt_nxt = last ? '0 : cnt_r + CNT_W'(1);
    end
    if (cfg_we) begin
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[design/rswct_fifo.sv]
module rswct_fifo
  import rswct_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     not_empty,
  output q_entry_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full      = cnt_r == CNT_W'(DEPTH);
  assign not_empty = cnt_r != '0;
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

[design/rswct_back.sv]
module rswct_back
  import rswct_pkg::*;
#(
  parameter int ROW_MAX = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_we,
  input  logic     q_valid,
  input  q_entry_t q_data,
  output logic     pop,
  rswct_out_if.source out_ch
);

  localparam int CNT_W = $clog2(ROW_MAX + 1);
  localparam int IDX_W = $clog2(ROW_MAX);

  bk_state_t        state_r, state_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic [CNT_W-1:0] ph_r, ph_nxt;
  logic [CNT_W-1:0] em_r, em_nxt;
  value_t           val_r [ROW_MAX];
  value_t           val_nxt [ROW_MAX];
  logic [TAG_W-1:0] tag_r [ROW_MAX];
  logic [TAG_W-1:0] tag_nxt [ROW_MAX];
  logic             out_load;
  logic             at_end;

  logic             out_vld_r;
  value_t           out_val_r;
  logic [TAG_W-1:0] out_tag_r;
  logic             out_done_r;

  assign at_end = (len_r - CNT_W'(1)) == ph_r;

  // The sort runs as odd-even transposition over the row cells: each phase
  // compares disjoint neighbor pairs and swaps only on strictly greater, so
  // equal values keep their order. A row of n values is sorted after n phases.
  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    len_nxt   = len_r;
    ph_nxt    = ph_r;
    em_nxt    = em_r;
    val_nxt   = val_r;
    tag_nxt   = tag_r;
    pop       = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      BK_LOAD: begin
        if (q_valid) begin
          pop = 1'b1;
          val_nxt[fill_r[IDX_W-1:0]] = q_data.value;
          tag_nxt[fill_r[IDX_W-1:0]] = q_data.tag;
          fill_nxt = fill_r + CNT_W'(1);
          if (q_data.last) begin
            len_nxt   = fill_r + CNT_W'(1);
            fill_nxt  = '0;
            ph_nxt    = '0;
            state_nxt = BK_SORT;
          end
        end
      end
      BK_SORT: begin
        for (int i = 0; i < ROW_MAX - 1; i++) begin
          if ((i[0] == ph_r[0]) && ((i + 1) < int'(len_r)) && (val_r[i] > val_r[i+1])) begin
            val_nxt[i]   = val_r[i+1];
            val_nxt[i+1] = val_r[i];
            tag_nxt[i]   = tag_r[i+1];
            tag_nxt[i+1] = tag_r[i];
          end
        end
        ph_nxt = ph_r + CNT_W'(1);
        if (at_end) begin
          em_nxt    = '0;
          state_nxt = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (!out_vld_r || out_ch.ready) begin
          out_load = 1'b1;
          for (int i = 0; i < ROW_MAX - 1; i++) begin
            val_nxt[i] = val_r[i+1];
            tag_nxt[i] = tag_r[i+1];
          end
          em_nxt = em_r + CNT_W'(1);
          if ((len_r - CNT_W'(1)) == em_r) begin
            state_nxt = BK_LOAD;
          end
        end
      end
      default: begin
        state_nxt = BK_LOAD;
      end
    endcase
    if (cfg_we) begin
      state_nxt = BK_LOAD;
      fill_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_LOAD;
      fill_r  <= '0;
      len_r   <= CNT_W'(1);
      ph_r    <= '0;
      em_r    <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      len_r   <= len_nxt;
      ph_r    <= ph_nxt;
      em_r    <= em_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    tag_r <= tag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_val_r  <= val_r[0];
      out_tag_r  <= tag_r[0];
      out_done_r <= (len_r - CNT_W'(1)) == em_r;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.sorted_value = out_val_r;
  assign out_ch.column_index = out_tag_r;
  assign out_ch.row_done     = out_done_r;

endmodule
